/* rtl/moc_pkg.sv */
// Types, constants and helpers shared by the mip chain offset calculator.
package moc_pkg;

	localparam int MAX_LEVELS  = 13;
	localparam int ALIGN_BYTES = 64;
	localparam int MAX_SLICES  = 512;
	localparam int CUBE_FACES  = 6;

	localparam int LVL_W   = 4;
	localparam int DIM_W   = 13;
	localparam int DEPTH_W = 10;
	localparam int TEXEL_W = 5;
	localparam int FACE_W  = 3;
	localparam int SLICE_W = 9;
	localparam int PITCH_W = 17;
	localparam int PROD_W  = DIM_W + TEXEL_W;
	localparam int SIZE_W  = PITCH_W + DIM_W;
	localparam int CHAIN_W = 32;
	localparam int OFF_W   = 40;
	localparam int CIDX_W  = 9;
	localparam int CHAINS_W = 10;
	localparam int CFG_W   = 13;
	localparam int REG_IDX_W = 3;

	localparam int MAX_DIM   = 4096;
	localparam int MAX_TEXEL = 16;
	localparam int DEPTH_MAX = (MAX_SLICES < 512) ? MAX_SLICES : 512;

	typedef enum logic [1:0] {
		KIND_PLAIN  = 2'd0,
		KIND_CUBE   = 2'd1,
		KIND_VOLUME = 2'd2,
		KIND_RSVD   = 2'd3
	} target_kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BASE_WIDTH    = 3'd0,
		REG_BASE_HEIGHT   = 3'd1,
		REG_BASE_DEPTH    = 3'd2,
		REG_TOP_LEVEL     = 3'd3,
		REG_TARGET_KIND   = 3'd4,
		REG_TEXEL_BYTES   = 3'd5,
		REG_LINEAR_LAYOUT = 3'd6,
		REG_WIDE_PITCH    = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		SEQ_START,
		SEQ_PITCH,
		SEQ_SIZE,
		SEQ_ACC,
		SEQ_TOTAL,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [FACE_W-1:0]  face_index;
		logic [LVL_W-1:0]   mip_level;
		logic [SLICE_W-1:0] slice_index;
	} query_t;

	typedef struct packed {
		logic [OFF_W-1:0]   img_byte_off;
		logic [PITCH_W-1:0] row_pitch;
		logic [DIM_W-1:0]   level_width;
		logic [DIM_W-1:0]   level_height;
		logic [OFF_W-1:0]   total_bytes;
		logic               bad_query;
	} result_t;

	// Chain layout handed from the layout sequencer to the query pipeline.
	typedef struct packed {
		logic                                busy;
		logic [LVL_W-1:0]                    last;
		target_kind_t                        kind;
		logic [DIM_W-1:0]                    bw;
		logic [DIM_W-1:0]                    bh;
		logic [DEPTH_W-1:0]                  bd;
		logic [MAX_LEVELS-1:0][CHAIN_W-1:0]  level_off;
		logic [MAX_LEVELS-1:0][PITCH_W-1:0]  level_pitch;
		logic [CHAIN_W-1:0]                  chain_bytes;
		logic [OFF_W-1:0]                    total;
	} layout_t;

	function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] h;
		h = v >> 1;
		return (h == '0) ? DIM_W'(1) : h;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		else
			return v;
	endfunction

endpackage

/* rtl/moc_layout.sv */
// Configuration registers and the sequencer that builds the per-level chain layout.
module moc_layout (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [moc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [moc_pkg::CFG_W-1:0]      cfg_data,
	output moc_pkg::layout_t               lay
);
	import moc_pkg::*;

	logic [DIM_W-1:0]   base_width_q, base_height_q;
	logic [DEPTH_W-1:0] base_depth_q;
	logic [LVL_W-1:0]   top_level_q;
	logic [1:0]         target_kind_q;
	logic [TEXEL_W-1:0] texel_bytes_q;
	logic               linear_layout_q, wide_pitch_q;

	seq_state_t state_q, state_n;
	logic       busy;

	logic [LVL_W-1:0]   lvl_q;
	logic [DIM_W-1:0]   w_q, h_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [SIZE_W-1:0]  sz_q;
	logic [CHAIN_W-1:0] pos_q;
	logic [OFF_W-1:0]   total_q;
	logic [MAX_LEVELS-1:0][CHAIN_W-1:0] off_q;
	logic [MAX_LEVELS-1:0][PITCH_W-1:0] lpitch_q;

	logic [DIM_W-1:0]    bw_c, bh_c;
	logic [DEPTH_W-1:0]  bd_c;
	logic [TEXEL_W-1:0]  tb_c;
	logic [LVL_W-1:0]    last_c;
	target_kind_t        kind_c;
	logic [CHAINS_W-1:0] chains_c;
	logic [PROD_W-1:0]   base_prod, lvl_prod, base_round;
	logic [PITCH_W-1:0]  pitch_n;
	logic [DIM_W-1:0]    nw, nh;
	logic [SIZE_W:0]     sz_ext, sz_round, sz_eff;
	logic                do_align;

	// Saturate registers into their legal ranges.
	always_comb begin
		bw_c = clamp_dim(base_width_q);
		bh_c = clamp_dim(base_height_q);
		if (base_depth_q == '0)
			bd_c = DEPTH_W'(1);
		else if (base_depth_q > DEPTH_W'(DEPTH_MAX))
			bd_c = DEPTH_W'(DEPTH_MAX);
		else
			bd_c = base_depth_q;
		if (texel_bytes_q == '0)
			tb_c = TEXEL_W'(1);
		else if (texel_bytes_q > TEXEL_W'(MAX_TEXEL))
			tb_c = TEXEL_W'(MAX_TEXEL);
		else
			tb_c = texel_bytes_q;
		last_c = (top_level_q > LVL_W'(MAX_LEVELS - 1)) ? LVL_W'(MAX_LEVELS - 1) : top_level_q;
		case (target_kind_q)
			KIND_CUBE:   kind_c = KIND_CUBE;
			KIND_VOLUME: kind_c = KIND_VOLUME;
			default:     kind_c = KIND_PLAIN;
		endcase
		case (kind_c)
			KIND_CUBE:   chains_c = CHAINS_W'(CUBE_FACES);
			KIND_VOLUME: chains_c = bd_c;
			default:     chains_c = CHAINS_W'(1);
		endcase
	end

	always_comb begin
		base_prod  = PROD_W'(bw_c) * PROD_W'(tb_c);
		lvl_prod   = PROD_W'(w_q) * PROD_W'(tb_c);
		base_round = PROD_W'(((base_prod + PROD_W'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES);
		pitch_n    = (wide_pitch_q && linear_layout_q) ? base_round[PITCH_W-1:0]
		                                               : lvl_prod[PITCH_W-1:0];
		nw       = halve(w_q);
		nh       = halve(h_q);
		do_align = (lvl_q < last_c) && !linear_layout_q && (nw > DIM_W'(1)) && (nh > DIM_W'(1));
		sz_ext   = {1'b0, sz_q};
		sz_round = (SIZE_W+1)'(((sz_ext + (SIZE_W+1)'(ALIGN_BYTES - 1)) / ALIGN_BYTES)
		           * ALIGN_BYTES);
		sz_eff   = do_align ? sz_round : sz_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_width_q    <= DIM_W'(1);
			base_height_q   <= DIM_W'(1);
			base_depth_q    <= DEPTH_W'(1);
			top_level_q     <= '0;
			target_kind_q   <= KIND_PLAIN;
			texel_bytes_q   <= TEXEL_W'(4);
			linear_layout_q <= 1'b1;
			wide_pitch_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_WIDTH:    base_width_q    <= cfg_data;
				REG_BASE_HEIGHT:   base_height_q   <= cfg_data;
				REG_BASE_DEPTH:    base_depth_q    <= cfg_data[DEPTH_W-1:0];
				REG_TOP_LEVEL:     top_level_q     <= cfg_data[LVL_W-1:0];
				REG_TARGET_KIND:   target_kind_q   <= cfg_data[1:0];
				REG_TEXEL_BYTES:   texel_bytes_q   <= cfg_data[TEXEL_W-1:0];
				REG_LINEAR_LAYOUT: linear_layout_q <= cfg_data[0];
				REG_WIDE_PITCH:    wide_pitch_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Three steps per level: pitch, size product, align and accumulate.
	always_comb begin
		state_n = state_q;
		busy    = 1'b1;
		unique case (state_q)
			SEQ_START: state_n = SEQ_PITCH;
			SEQ_PITCH: state_n = SEQ_SIZE;
			SEQ_SIZE:  state_n = SEQ_ACC;
			SEQ_ACC:   state_n = (lvl_q == last_c) ? SEQ_TOTAL : SEQ_PITCH;
			SEQ_TOTAL: state_n = SEQ_DONE;
			SEQ_DONE:  busy = 1'b0;
			default:   state_n = SEQ_START;
		endcase
		if (cfg_we)
			state_n = SEQ_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SEQ_START;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SEQ_START: begin
				lvl_q <= '0;
				w_q   <= bw_c;
				h_q   <= bh_c;
				pos_q <= '0;
			end
			SEQ_PITCH: pitch_q <= pitch_n;
			SEQ_SIZE:  sz_q <= SIZE_W'(pitch_q) * SIZE_W'(h_q);
			SEQ_ACC: begin
				for (int i = 0; i < MAX_LEVELS; i++) begin
					if (lvl_q == LVL_W'(i)) begin
						off_q[i]    <= pos_q;
						lpitch_q[i] <= pitch_q;
					end
				end
				pos_q <= pos_q + CHAIN_W'(sz_eff);
				w_q   <= nw;
				h_q   <= nh;
				lvl_q <= lvl_q + LVL_W'(1);
			end
			SEQ_TOTAL: total_q <= OFF_W'(pos_q) * OFF_W'(chains_c);
			default: ;
		endcase
	end

	always_comb begin
		lay.busy        = busy;
		lay.last        = last_c;
		lay.kind        = kind_c;
		lay.bw          = bw_c;
		lay.bh          = bh_c;
		lay.bd          = bd_c;
		lay.level_off   = off_q;
		lay.level_pitch = lpitch_q;
		lay.chain_bytes = pos_q;
		lay.total       = total_q;
	end

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == SEQ_START))
		else $error("config write did not restart layout build");
	a_lvl_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_ACC) |-> (lvl_q <= last_c))
		else $error("layout build ran past the last level");

endmodule

/* rtl/moc_query.sv */
// Three-stage query pipeline: table select and checks, chain product, offset add.
module moc_query (
	input  logic              clk,
	input  logic              arst_n,
	input  moc_pkg::layout_t  lay,
	input  logic              query_valid,
	output logic              query_stall,
	input  moc_pkg::query_t   query,
	output logic              result_valid,
	input  logic              result_stall,
	output moc_pkg::result_t  result
);
	import moc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3, accept;

	logic               bad_s1, bad_s2;
	logic [CIDX_W-1:0]  cidx_s1;
	logic [CHAIN_W-1:0] loff_s1, loff_s2;
	logic [PITCH_W-1:0] pitch_s1, pitch_s2;
	logic [DIM_W-1:0]   w_s1, w_s2, h_s1, h_s2;
	logic [OFF_W-1:0]   prod_s2;
	result_t            res_s3;

	logic               bad_c;
	logic [CIDX_W-1:0]  cidx_c;
	logic [CHAIN_W-1:0] loff_c;
	logic [PITCH_W-1:0] pitch_c;
	logic [DIM_W-1:0]   wsh_c, hsh_c;

	always_comb begin
		en3 = !v_s3 || !result_stall;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
		query_stall = lay.busy || !en1;
		accept = query_valid && !query_stall;
	end

	always_comb begin
		bad_c  = query.mip_level > lay.last;
		cidx_c = '0;
		case (lay.kind)
			KIND_CUBE: begin
				cidx_c = CIDX_W'(query.face_index);
				if (query.face_index >= FACE_W'(CUBE_FACES))
					bad_c = 1'b1;
			end
			KIND_VOLUME: begin
				cidx_c = query.slice_index;
				if (DEPTH_W'(query.slice_index) >= lay.bd)
					bad_c = 1'b1;
			end
			default: ;
		endcase
		loff_c  = '0;
		pitch_c = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (query.mip_level == LVL_W'(i)) begin
				loff_c  = lay.level_off[i];
				pitch_c = lay.level_pitch[i];
			end
		end
		wsh_c = lay.bw >> query.mip_level;
		hsh_c = lay.bh >> query.mip_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= accept;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bad_s1   <= bad_c;
			cidx_s1  <= cidx_c;
			loff_s1  <= loff_c;
			pitch_s1 <= pitch_c;
			w_s1     <= (wsh_c == '0) ? DIM_W'(1) : wsh_c;
			h_s1     <= (hsh_c == '0) ? DIM_W'(1) : hsh_c;
		end
		if (en2) begin
			bad_s2   <= bad_s1;
			loff_s2  <= loff_s1;
			pitch_s2 <= pitch_s1;
			w_s2     <= w_s1;
			h_s2     <= h_s1;
			prod_s2  <= OFF_W'(cidx_s1) * OFF_W'(lay.chain_bytes);
		end
		if (en3) begin
			res_s3.img_byte_off <= bad_s2 ? '0 : OFF_W'(loff_s2) + prod_s2;
			res_s3.row_pitch    <= bad_s2 ? '0 : pitch_s2;
			res_s3.level_width  <= bad_s2 ? '0 : w_s2;
			res_s3.level_height <= bad_s2 ? '0 : h_s2;
			res_s3.total_bytes  <= lay.total;
			res_s3.bad_query    <= bad_s2;
		end
	end

	assign result_valid = v_s3;
	assign result       = res_s3;

	a_bad_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.bad_query) |->
		(result.img_byte_off == '0 && result.row_pitch == '0 && result.level_width == '0))
		else $error("rejected query carries nonzero fields");
	a_good_dims: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.bad_query) |->
		(result.level_width != '0 && result.level_height != '0))
		else $error("valid query with zero dimension");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lay.busy |-> !accept)
		else $error("query taken while layout is rebuilding");

endmodule

/* rtl/mip_chain_offset_calc.sv */
// Top level of the mip chain offset calculator.
//
//   channel   direction  handshake                    payload
//   cfg       in         cfg_we                       cfg_index, cfg_data
//   query     in         query_valid / query_stall    query (face, level, slice)
//   result    out        result_valid / result_stall  result (offset, pitch, dims, total, bad)
//
// One query per cycle while query_stall is low, through the select, multiply and add
// stages. After reset and after every config write the layout sequencer rebuilds the level
// table, three steps per level (pitch, size product, align and accumulate); query_stall
// stays high meanwhile. result_stall holds a waiting result in place and stalls the stages
// behind it as they fill; nothing is dropped or repeated. Reset is asynchronous, active low.
module mip_chain_offset_calc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [moc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [moc_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           query_valid,
	output logic                           query_stall,
	input  moc_pkg::query_t                query,
	output logic                           result_valid,
	input  logic                           result_stall,
	output moc_pkg::result_t               result
);
	import moc_pkg::*;

	layout_t lay;

	moc_layout u_layout (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.lay       (lay)
	);

	moc_query u_query (
		.clk          (clk),
		.arst_n       (arst_n),
		.lay          (lay),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* tb/mip_chain_offset_calc_tb.sv */
// Self-checking testbench for the mip chain offset calculator.
`timescale 1ns / 100ps

module mip_chain_offset_calc_tb;
	import moc_pkg::*;

	localparam int REG_COUNT = 8;
	localparam int HOLD_CYCLES = 120;

	// Predicts each query's layout and holds the results still owed by the block.
	class mip_layout_book;
		logic [DIM_W-1:0]   cfg_bw;
		logic [DIM_W-1:0]   cfg_bh;
		logic [DEPTH_W-1:0] cfg_bd;
		logic [LVL_W-1:0]   cfg_top;
		target_kind_t       cfg_kind;
		logic [TEXEL_W-1:0] cfg_tb;
		logic               cfg_lin;
		logic               cfg_wide;
		result_t            owed_layouts[$];
		int                 errors;
		int                 n_checked;
		int                 n_bad;

		function new();
			cfg_bw = 1;
			cfg_bh = 1;
			cfg_bd = 1;
			cfg_top = 0;
			cfg_kind = KIND_PLAIN;
			cfg_tb = 4;
			cfg_lin = 1'b1;
			cfg_wide = 1'b0;
			errors = 0;
			n_checked = 0;
			n_bad = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_BASE_WIDTH:    cfg_bw = v[DIM_W-1:0];
				REG_BASE_HEIGHT:   cfg_bh = v[DIM_W-1:0];
				REG_BASE_DEPTH:    cfg_bd = v[DEPTH_W-1:0];
				REG_TOP_LEVEL:     cfg_top = v[LVL_W-1:0];
				REG_TARGET_KIND:   cfg_kind = target_kind_t'(v[1:0]);
				REG_TEXEL_BYTES:   cfg_tb = v[TEXEL_W-1:0];
				REG_LINEAR_LAYOUT: cfg_lin = v[0];
				REG_WIDE_PITCH:    cfg_wide = v[0];
				default: ;
			endcase
		endfunction

		function logic [63:0] clip(logic [63:0] v, logic [63:0] lo, logic [63:0] hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function logic [63:0] shrink(logic [63:0] v);
			return (v >> 1) == 0 ? 64'd1 : v >> 1;
		endfunction

		function logic [63:0] align_up(logic [63:0] v);
			return ((v + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
		endfunction

		function result_t layout_of(query_t q);
			logic [63:0] bw, bh, bd, tb, last, chains, cidx;
			logic [63:0] w, h, nw, nh, pitch, sz, pos;
			logic [63:0] q_off, q_pitch, q_w, q_h, total;
			logic        bad;
			result_t     r;
			bw = clip(cfg_bw, 1, MAX_DIM);
			bh = clip(cfg_bh, 1, MAX_DIM);
			bd = clip(cfg_bd, 1, DEPTH_MAX);
			tb = clip(cfg_tb, 1, MAX_TEXEL);
			last = (cfg_top > MAX_LEVELS - 1) ? MAX_LEVELS - 1 : cfg_top;
			chains = 1;
			cidx = 0;
			bad = 1'b0;
			// reserved kind falls through as plain
			if (cfg_kind == KIND_CUBE) begin
				chains = CUBE_FACES;
				cidx = q.face_index;
				bad = (q.face_index >= CUBE_FACES);
			end else if (cfg_kind == KIND_VOLUME) begin
				chains = bd;
				cidx = q.slice_index;
				bad = (q.slice_index >= bd);
			end
			if (q.mip_level > last)
				bad = 1'b1;
			w = bw;
			h = bh;
			pos = 0;
			q_off = 0;
			q_pitch = 0;
			q_w = 0;
			q_h = 0;
			for (int l = 0; l <= last; l++) begin
				nw = shrink(w);
				nh = shrink(h);
				pitch = (cfg_wide && cfg_lin) ? align_up(bw * tb) : w * tb;
				sz = pitch * h;
				// swizzled levels get padded unless the next one is a line or the tail
				if (l < last && !cfg_lin && nw > 1 && nh > 1)
					sz = align_up(sz);
				if (l == q.mip_level) begin
					q_off = pos;
					q_pitch = pitch;
					q_w = w;
					q_h = h;
				end
				pos += sz;
				w = nw;
				h = nh;
			end
			total = pos * chains;
			if (bad) begin
				q_off = 0;
				q_pitch = 0;
				q_w = 0;
				q_h = 0;
			end else begin
				q_off += cidx * pos;
			end
			r.img_byte_off = q_off[OFF_W-1:0];
			r.row_pitch = q_pitch[PITCH_W-1:0];
			r.level_width = q_w[DIM_W-1:0];
			r.level_height = q_h[DIM_W-1:0];
			r.total_bytes = total[OFF_W-1:0];
			r.bad_query = bad;
			return r;
		endfunction

		function void note_query(query_t q);
			owed_layouts.push_back(layout_of(q));
		endfunction

		function int pending();
			return owed_layouts.size();
		endfunction

		function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(result_t act);
			result_t e;
			if (owed_layouts.size() == 0) begin
				$display("%0t: result with none outstanding, expected nothing, got %h",
					$time, act);
				errors++;
				return;
			end
			e = owed_layouts.pop_front();
			n_checked++;
			if (e.bad_query)
				n_bad++;
			cmp_field("img_byte_off", e.img_byte_off, act.img_byte_off);
			cmp_field("row_pitch", e.row_pitch, act.row_pitch);
			cmp_field("level_width", e.level_width, act.level_width);
			cmp_field("level_height", e.level_height, act.level_height);
			cmp_field("total_bytes", e.total_bytes, act.total_bytes);
			cmp_field("bad_query", e.bad_query, act.bad_query);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             query_valid;
	logic             query_stall;
	query_t           query;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;

	logic calm = 1'b0;
	logic hold_go = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;
	int   n_settings = 0;

	mip_layout_book sb = new();

	mip_chain_offset_calc dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Result side: random stalls, one long hold to back the pipe up, check every transfer.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (calm) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(0, 99) < 25);
		end
	end

	function automatic query_t mk_q(int f, int l, int s);
		query_t q;
		q.face_index = FACE_W'(f);
		q.mip_level = LVL_W'(l);
		q.slice_index = SLICE_W'(s);
		return q;
	endfunction

	task automatic send_query(query_t q);
		while (!calm && $urandom_range(0, 99) < 25) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query <= q;
		@(posedge clk);
		while (query_stall)
			@(posedge clk);
		sb.note_query(q);
	endtask

	task automatic program_regs(logic [CFG_W-1:0] regs [REG_COUNT]);
		for (int i = 0; i < REG_COUNT; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_data <= regs[i];
			@(posedge clk);
			sb.set_reg(reg_idx_t'(i), regs[i]);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Wait out every owed result plus the pipe latency so the block is idle.
	task automatic drain();
		query_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick(int lo, int hi, int edge_lo, int edge_hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
		if (r < 20)
			return CFG_W'(edge_lo);
		if (r < 30)
			return CFG_W'(edge_hi);
		if (r < 65)
			return CFG_W'($urandom_range(lo, (hi < 16) ? hi : 16));
		return CFG_W'($urandom_range(lo, hi));
	endfunction

	task automatic run_random_phase(int n_items);
		logic [CFG_W-1:0] regs [REG_COUNT];
		int     last;
		int     depth;
		query_t q;
		regs[REG_BASE_WIDTH] = pick(1, MAX_DIM, 1, MAX_DIM);
		regs[REG_BASE_HEIGHT] = pick(1, MAX_DIM, 1, MAX_DIM);
		regs[REG_BASE_DEPTH] = pick(1, DEPTH_MAX, 1, DEPTH_MAX);
		regs[REG_TOP_LEVEL] = pick(0, MAX_LEVELS - 1, 0, MAX_LEVELS - 1);
		regs[REG_TARGET_KIND] = ($urandom_range(0, 99) < 10) ? CFG_W'(KIND_RSVD) :
			CFG_W'($urandom_range(KIND_PLAIN, KIND_VOLUME));
		regs[REG_TEXEL_BYTES] = pick(1, MAX_TEXEL, 1, MAX_TEXEL);
		regs[REG_LINEAR_LAYOUT] = CFG_W'($urandom_range(0, 1));
		regs[REG_WIDE_PITCH] = CFG_W'($urandom_range(0, 1));
		program_regs(regs);
		last = regs[REG_TOP_LEVEL][LVL_W-1:0];
		if (last > MAX_LEVELS - 1)
			last = MAX_LEVELS - 1;
		depth = regs[REG_BASE_DEPTH][DEPTH_W-1:0];
		if (depth == 0)
			depth = 1;
		if (depth > DEPTH_MAX)
			depth = DEPTH_MAX;
		repeat (n_items) begin
			// mostly in-range queries, the rest raw bits to hit the error paths
			if ($urandom_range(0, 99) < 80)
				q = mk_q($urandom_range(0, CUBE_FACES - 1), $urandom_range(0, last),
					$urandom_range(0, depth - 1));
			else
				q = query_t'((FACE_W + LVL_W + SLICE_W)'($urandom));
			send_query(q);
		end
		drain();
	endtask

	initial begin
		logic [CFG_W-1:0] regs [REG_COUNT];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		query_valid = 1'b0;
		query = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: plain 1x1, unused face/slice ignored, level past the top
		send_query(mk_q(0, 0, 0));
		send_query(mk_q(7, 15, 511));
		send_query(mk_q(5, 0, 300));
		drain();

		// largest swizzled cube, faces past the sixth
		regs = '{13'd4096, 13'd4096, 13'd0, 13'd12, CFG_W'(KIND_CUBE), 13'd16, 13'd0, 13'd0};
		program_regs(regs);
		send_query(mk_q(5, 12, 0));
		send_query(mk_q(0, 0, 0));
		send_query(mk_q(6, 0, 0));
		send_query(mk_q(7, 3, 0));
		send_query(mk_q(2, 13, 0));
		send_query(mk_q(3, 15, 511));
		drain();

		// saturated registers: width 0, height/depth/top too large, texel 0, wide pitch
		regs = '{13'd0, 13'd8191, 13'd1023, 13'd15, CFG_W'(KIND_VOLUME), 13'd0, 13'd1, 13'd1};
		program_regs(regs);
		send_query(mk_q(7, 0, 511));
		send_query(mk_q(0, 12, 0));
		send_query(mk_q(3, 5, 255));
		drain();

		// small volume, slices past the depth
		regs = '{13'd4095, 13'd3, 13'd5, 13'd11, CFG_W'(KIND_VOLUME), 13'd31, 13'd1, 13'd1};
		program_regs(regs);
		send_query(mk_q(0, 0, 4));
		send_query(mk_q(0, 0, 5));
		send_query(mk_q(0, 11, 511));
		send_query(mk_q(0, 12, 0));
		drain();

		// reserved kind acts as plain; wide pitch has no effect when swizzled
		regs = '{13'd8191, 13'd0, 13'd0, 13'd12, CFG_W'(KIND_RSVD), 13'd17, 13'd0, 13'd1};
		program_regs(regs);
		send_query(mk_q(6, 12, 400));
		send_query(mk_q(0, 0, 0));
		send_query(mk_q(7, 13, 0));
		drain();

		for (int p = 0; p < 9; p++) begin
			if (p == 4) begin
				// no idling here; the result hold backs up into the query side
				calm <= 1'b1;
				hold_go <= 1'b1;
				@(posedge clk);
				run_random_phase(100);
				calm <= 1'b0;
			end else begin
				run_random_phase(68);
			end
		end

		$display("Checked %0d queries (%0d out of range) across %0d register settings,",
			sb.n_checked, sb.n_bad, n_settings);
		$display("with saturated registers, all target kinds and a long result hold.");
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
